// File: src/csh_pkg.sv
`timescale 1ns / 1ps

package csh_pkg;

	localparam int COORD_BITS = 24;
	localparam int DIST_BITS  = ((2 * COORD_BITS) + 2 > 64) ? 64 : (2 * COORD_BITS) + 2;
	localparam int DIFF_W     = COORD_BITS + 1;
	localparam int CROSS_W    = (2 * DIFF_W) + 1;
	localparam int NUM_W      = CROSS_W + COORD_BITS;
	localparam int QUO_W      = DIFF_W;
	localparam int SQ_W       = (2 * QUO_W) + 1;
	localparam int CNT_W      = $clog2(NUM_W + 1);
	localparam int IDX_W      = 3;
	localparam int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((2 * COORD_BITS + DIST_BITS + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] REG_QUERY_X      = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_QUERY_Y      = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_QUERY_DX     = IDX_W'(2);
	localparam logic [IDX_W-1:0] REG_QUERY_DY     = IDX_W'(3);
	localparam logic [IDX_W-1:0] REG_SEGMENT_MODE = IDX_W'(4);
	localparam logic [IDX_W-1:0] REG_MIN_DIST2    = IDX_W'(5);

	localparam logic [DIST_BITS-1:0] MIN_DIST2_RESET = DIST_BITS'(167772);
	localparam logic [DIST_BITS-1:0] DIST_MAX        = {DIST_BITS{1'b1}};

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	function automatic logic signed [CROSS_W-1:0] pp_term(
		input logic                       b,
		input logic signed [CROSS_W-1:0]  m,
		input logic                       msb
	);
		logic signed [CROSS_W-1:0] t;
		t = b ? m : '0;
		return msb ? -t : t;
	endfunction

endpackage

// File: src/closest_segment_hit.sv
`timescale 1ns / 1ps
// Channel   Dir  Transfer                  Payload
// s_axis    in   tvalid & tready           tdata: edge_ax, edge_ay, edge_bx, edge_by; tlast
// m_axis    out  tvalid & tready           tdata: hit_x, hit_y, hit_dist2; tuser: hit
// cfg       in   cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One edge at a time. An edge runs through the bit-serial cross products, the scaling
// multiply, the restoring divider (one quotient bit per cycle over the full numerator)
// and the squaring. A parallel edge is dropped after the cross products. Reset clears
// the query and the best hit.
// A pending result stalls only the edge marked last; other edges keep flowing.

module closest_segment_hit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [csh_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // edge_ax, edge_ay, edge_bx, edge_by
	input  logic                               s_axis_tlast,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [csh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // hit_x, hit_y, hit_dist2
	output logic                               m_axis_tuser,   // hit
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [csh_pkg::IDX_W-1:0]          cfg_index,
	input  logic [csh_pkg::DIST_BITS-1:0]      cfg_data
);
	import csh_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_CROSS  = 8'b0000_0010,
		S_CHECK  = 8'b0000_0100,
		S_SCALE  = 8'b0000_1000,
		S_DIVIDE = 8'b0001_0000,
		S_SQUARE = 8'b0010_0000,
		S_UPDATE = 8'b0100_0000,
		S_FINISH = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	logic signed [COORD_BITS-1:0] query_x_q, query_y_q, query_dx_q, query_dy_q;
	logic                         segment_mode_q;
	logic [DIST_BITS-1:0]         min_dist2_q;

	logic                         last_q;
	logic signed [CROSS_W-1:0]    m_dx_q, m_dy_q, m_qx_q, m_qy_q;
	logic [DIFF_W-1:0]            b_sy_q, b_sx_q, b_dy_q, b_dx_q;
	logic signed [CROSS_W-1:0]    den_q, tn_q, un_q;

	logic [CROSS_W-1:0]           den_mag_q;
	logic [NUM_W-1:0]             tnm_q, num_x_q, num_y_q;
	logic [COORD_BITS-1:0]        ax_q, ay_q;
	logic                         neg_x_q, neg_y_q;

	logic [SQ_W-1:0]              sqm_x_q, sqm_y_q, d2_q;
	logic [QUO_W-1:0]             sqb_x_q, sqb_y_q;

	logic [DIST_BITS-1:0]         best_dist2_q;
	logic [COORD_BITS-1:0]        best_x_q, best_y_q;
	logic                         have_hit_q;

	logic                         out_valid_q, out_hit_q;
	logic [COORD_BITS-1:0]        out_x_q, out_y_q;
	logic [DIST_BITS-1:0]         out_dist2_q;

	div_ctl_t                     div_ctl;
	logic [QUO_W-1:0]             quo_x, quo_y;
	logic                         big_x, big_y;

	logic signed [COORD_BITS-1:0] e_ax, e_ay, e_bx, e_by;
	logic signed [DIFF_W-1:0]     sx, sy, qx, qy, dx_w, dy_w;
	logic                         in_fire, msb;
	logic signed [CROSS_W-1:0]    den_a, tn_a, un_a;
	logic                         reject;
	logic                         sat;
	logic [DIST_BITS-1:0]         cand_d2;
	logic [COORD_BITS-1:0]        off_x, off_y;
	logic                         take;
	logic                         emit;

	always_comb begin
		e_ax    = s_axis_tdata[0*COORD_BITS +: COORD_BITS];
		e_ay    = s_axis_tdata[1*COORD_BITS +: COORD_BITS];
		e_bx    = s_axis_tdata[2*COORD_BITS +: COORD_BITS];
		e_by    = s_axis_tdata[3*COORD_BITS +: COORD_BITS];
		sx      = DIFF_W'(e_bx) - DIFF_W'(e_ax);
		sy      = DIFF_W'(e_by) - DIFF_W'(e_ay);
		qx      = DIFF_W'(e_ax) - DIFF_W'(query_x_q);
		qy      = DIFF_W'(e_ay) - DIFF_W'(query_y_q);
		dx_w    = DIFF_W'(query_dx_q);
		dy_w    = DIFF_W'(query_dy_q);
		in_fire = s_axis_tvalid && s_axis_tready;
		msb     = cnt_q == CNT_W'(DIFF_W - 1);

		den_a  = den_q[CROSS_W-1] ? -den_q : den_q;
		tn_a   = den_q[CROSS_W-1] ? -tn_q : tn_q;
		un_a   = den_q[CROSS_W-1] ? -un_q : un_q;
		reject = (den_q == '0) || tn_a[CROSS_W-1] || un_a[CROSS_W-1] || (un_a > den_a)
			|| (segment_mode_q && (tn_a > den_a));

		sat     = big_x || big_y || (d2_q > SQ_W'(DIST_MAX));
		cand_d2 = sat ? DIST_MAX : d2_q[DIST_BITS-1:0];
		off_x   = neg_x_q ? -quo_x[COORD_BITS-1:0] : quo_x[COORD_BITS-1:0];
		off_y   = neg_y_q ? -quo_y[COORD_BITS-1:0] : quo_y[COORD_BITS-1:0];
		take    = (cand_d2 > min_dist2_q) && (!have_hit_q || (cand_d2 < best_dist2_q));
		emit    = (state_q == S_FINISH) && last_q && (!out_valid_q || m_axis_tready);

		div_ctl.load = (state_q == S_DIVIDE) && (cnt_q == '0);
		div_ctl.step = (state_q == S_DIVIDE) && (cnt_q != '0);
	end

	csh_div u_div_x (
		.clk (clk),
		.ctl (div_ctl),
		.num (num_x_q),
		.den (den_mag_q),
		.quo (quo_x),
		.big (big_x)
	);

	csh_div u_div_y (
		.clk (clk),
		.ctl (div_ctl),
		.num (num_y_q),
		.den (den_mag_q),
		.quo (quo_y),
		.big (big_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_x_q      <= '0;
			query_y_q      <= '0;
			query_dx_q     <= '0;
			query_dy_q     <= '0;
			segment_mode_q <= 1'b0;
			min_dist2_q    <= MIN_DIST2_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_QUERY_X:      query_x_q      <= cfg_data[COORD_BITS-1:0];
				REG_QUERY_Y:      query_y_q      <= cfg_data[COORD_BITS-1:0];
				REG_QUERY_DX:     query_dx_q     <= cfg_data[COORD_BITS-1:0];
				REG_QUERY_DY:     query_dy_q     <= cfg_data[COORD_BITS-1:0];
				REG_SEGMENT_MODE: segment_mode_q <= cfg_data[0];
				REG_MIN_DIST2:    min_dist2_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			best_dist2_q <= DIST_MAX;
			best_x_q     <= '0;
			best_y_q     <= '0;
			have_hit_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					if (in_fire)
						state_q <= S_CROSS;
				end
				S_CROSS: begin
					cnt_q <= cnt_q + 1'b1;
					if (msb)
						state_q <= S_CHECK;
				end
				S_CHECK: begin
					cnt_q   <= '0;
					state_q <= reject ? S_FINISH : S_SCALE;
				end
				S_SCALE: begin
					if (cnt_q == CNT_W'(COORD_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_DIVIDE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_DIVIDE: begin
					if (cnt_q == CNT_W'(NUM_W)) begin
						cnt_q   <= '0;
						state_q <= S_SQUARE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_SQUARE: begin
					if (cnt_q == CNT_W'(QUO_W)) begin
						cnt_q   <= '0;
						state_q <= S_UPDATE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_UPDATE: begin
					state_q <= S_FINISH;
					if (take) begin
						have_hit_q   <= 1'b1;
						best_dist2_q <= cand_d2;
						best_x_q     <= query_x_q + off_x;
						best_y_q     <= query_y_q + off_y;
					end
				end
				S_FINISH: begin
					if (!last_q) begin
						state_q <= S_IDLE;
					end else if (emit) begin
						best_dist2_q <= DIST_MAX;
						best_x_q     <= '0;
						best_y_q     <= '0;
						have_hit_q   <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			last_q <= s_axis_tlast;
			m_dx_q <= CROSS_W'(dx_w);
			m_dy_q <= CROSS_W'(dy_w);
			m_qx_q <= CROSS_W'(qx);
			m_qy_q <= CROSS_W'(qy);
			b_sy_q <= sy;
			b_sx_q <= sx;
			b_dy_q <= dy_w;
			b_dx_q <= dx_w;
			den_q  <= '0;
			tn_q   <= '0;
			un_q   <= '0;
		end
		if (state_q == S_CROSS) begin
			den_q  <= den_q + pp_term(b_sy_q[0], m_dx_q, msb) - pp_term(b_sx_q[0], m_dy_q, msb);
			tn_q   <= tn_q + pp_term(b_sy_q[0], m_qx_q, msb) - pp_term(b_sx_q[0], m_qy_q, msb);
			un_q   <= un_q + pp_term(b_dy_q[0], m_qx_q, msb) - pp_term(b_dx_q[0], m_qy_q, msb);
			m_dx_q <= m_dx_q <<< 1;
			m_dy_q <= m_dy_q <<< 1;
			m_qx_q <= m_qx_q <<< 1;
			m_qy_q <= m_qy_q <<< 1;
			b_sy_q <= b_sy_q >> 1;
			b_sx_q <= b_sx_q >> 1;
			b_dy_q <= b_dy_q >> 1;
			b_dx_q <= b_dx_q >> 1;
		end
		if (state_q == S_CHECK) begin
			den_mag_q <= $unsigned(den_a);
			tnm_q     <= NUM_W'($unsigned(tn_a));
			ax_q      <= query_dx_q[COORD_BITS-1] ? $unsigned(-query_dx_q) : $unsigned(query_dx_q);
			ay_q      <= query_dy_q[COORD_BITS-1] ? $unsigned(-query_dy_q) : $unsigned(query_dy_q);
			neg_x_q   <= query_dx_q[COORD_BITS-1];
			neg_y_q   <= query_dy_q[COORD_BITS-1];
			num_x_q   <= '0;
			num_y_q   <= '0;
		end
		if (state_q == S_SCALE) begin
			num_x_q <= num_x_q + (ax_q[0] ? tnm_q : '0);
			num_y_q <= num_y_q + (ay_q[0] ? tnm_q : '0);
			tnm_q   <= tnm_q << 1;
			ax_q    <= ax_q >> 1;
			ay_q    <= ay_q >> 1;
		end
		if (state_q == S_SQUARE) begin
			if (cnt_q == '0) begin
				sqm_x_q <= SQ_W'(quo_x);
				sqm_y_q <= SQ_W'(quo_y);
				sqb_x_q <= quo_x;
				sqb_y_q <= quo_y;
				d2_q    <= '0;
			end else begin
				d2_q    <= d2_q + (sqb_x_q[0] ? sqm_x_q : '0) + (sqb_y_q[0] ? sqm_y_q : '0);
				sqm_x_q <= sqm_x_q << 1;
				sqm_y_q <= sqm_y_q << 1;
				sqb_x_q <= sqb_x_q >> 1;
				sqb_y_q <= sqb_y_q >> 1;
			end
		end
		if (emit) begin
			out_hit_q   <= have_hit_q;
			out_x_q     <= best_x_q;
			out_y_q     <= best_y_q;
			out_dist2_q <= best_dist2_q;
		end
	end

	assign s_axis_tready = state_q == S_IDLE;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_hit_q;
	assign m_axis_tdata  = OUT_DATA_W'({out_dist2_q, out_y_q, out_x_q});

endmodule

// File: src/csh_div.sv
`timescale 1ns / 1ps

module csh_div (
	input  logic                          clk,
	input  csh_pkg::div_ctl_t             ctl,
	input  logic [csh_pkg::NUM_W-1:0]     num,
	input  logic [csh_pkg::CROSS_W-1:0]   den,
	output logic [csh_pkg::QUO_W-1:0]     quo,
	output logic                          big
);
	import csh_pkg::*;

	logic [NUM_W-1:0]   num_q;
	logic [CROSS_W-1:0] rem_q;
	logic [QUO_W-1:0]   quo_q;
	logic               big_q;
	logic [CROSS_W:0]   trial;
	logic [CROSS_W:0]   diff;
	logic               fits;

	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		fits  = trial >= {1'b0, den};
		diff  = trial - {1'b0, den};
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			num_q <= num;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (ctl.step) begin
			num_q <= num_q << 1;
			rem_q <= fits ? diff[CROSS_W-1:0] : trial[CROSS_W-1:0];
			quo_q <= {quo_q[QUO_W-2:0], fits};
			big_q <= big_q | quo_q[QUO_W-1];
		end
	end

	assign quo = quo_q;
	assign big = big_q;

endmodule
